[rtl/rv32e_pkg.sv]
// Package for the RV32I execute core: opcodes, event codes, register indexes,
// input and result word types. Used by the regfile, exec and top-level files.
package rv32e_pkg;

  localparam int unsigned NumRegsDefault = 32;
  localparam logic [31:0] StackResetValue = 32'h8000_0000;

  localparam logic [6:0] OpLui    = 7'b0110111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpImm    = 7'b0010011;
  localparam logic [6:0] OpReg    = 7'b0110011;
  localparam logic [6:0] OpSystem = 7'b1110011;
  localparam logic [6:0] OpFence  = 7'b0001111;

  localparam logic [6:0] Funct7Alt = 7'h20;

  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvIllegal = 3'd1;
  localparam logic [2:0] EvEcall   = 3'd2;
  localparam logic [2:0] EvEbreak  = 3'd3;
  localparam logic [2:0] EvFault   = 3'd4;

  localparam logic       CfgStartAddr = 1'b0;
  localparam logic       CfgStackPtr  = 1'b1;

  localparam logic [4:0] RegSp = 5'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] instruction;
    logic [31:0] load_data;
    logic        mem_fault;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [2:0]  event_res;
    logic        halted;
    logic [31:0] trap_value;
    logic        mem_request;
    logic        mem_is_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic        writeback_valid;
    logic [4:0]  writeback_reg;
    logic [31:0] writeback_value;
  } out_word_t;

endpackage

[rtl/rv32e_stream_if.sv]
// Valid/ready channel carrying one word of type word_t.
// No dependencies; the word type is a parameter.
interface rv32e_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rv32e_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module rv32e_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end
endmodule

[rtl/rv32e_regfile.sv]
// Register file: RAM plus per-entry valid bits (reset reads zero, x2 = sp),
// and write-to-read forwarding. Depends on rv32e_pkg and rv32e_ram.
module rv32e_regfile import rv32e_pkg::*; #(
  parameter int unsigned NumRegs = NumRegsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [4:0]  raddr_a_i,
  input  logic [4:0]  raddr_b_i,
  input  logic [31:0] sp_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o
);
  localparam int unsigned AW = $clog2(NumRegs);

  logic [NumRegs-1:0] valid_q;
  logic [31:0]        ram_a, ram_b;
  logic               fwd_a_q, fwd_b_q, vld_a_q, vld_b_q, sp_a_q, sp_b_q;
  logic [31:0]        fwd_data_q;
  logic               in_a, in_b, wr_ok;

  assign in_a  = {1'b0, raddr_a_i} < 6'(NumRegs);
  assign in_b  = {1'b0, raddr_b_i} < 6'(NumRegs);
  assign wr_ok = we_i && ({1'b0, waddr_i} < 6'(NumRegs)) && (waddr_i != '0);

  rv32e_ram #(.Width(32), .Depth(NumRegs)) u_ram (
    .clk_i,
    .we_i      (wr_ok),
    .waddr_i   (waddr_i[AW-1:0]),
    .wdata_i,
    .raddr_a_i (raddr_a_i[AW-1:0]),
    .raddr_b_i (raddr_b_i[AW-1:0]),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      sp_a_q  <= 1'b0;
      sp_b_q  <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[waddr_i[AW-1:0]] <= 1'b1;
      end
      fwd_a_q <= wr_ok && waddr_i == raddr_a_i;
      fwd_b_q <= wr_ok && waddr_i == raddr_b_i;
      vld_a_q <= in_a && valid_q[raddr_a_i[AW-1:0]];
      vld_b_q <= in_b && valid_q[raddr_b_i[AW-1:0]];
      sp_a_q  <= raddr_a_i == RegSp;
      sp_b_q  <= raddr_b_i == RegSp;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata_i;
  end

  // until x2 is first written (by the core or by a config write) the reset
  // stack pointer stands in for it
  assign rdata_a_o = fwd_a_q ? fwd_data_q : vld_a_q ? ram_a : sp_a_q ? sp_i : '0;
  assign rdata_b_o = fwd_b_q ? fwd_data_q : vld_b_q ? ram_b : sp_b_q ? sp_i : '0;
endmodule

[rtl/rv32e_exec.sv]
// Decode, ALU, branch, load/store sequencing for one instruction word.
// Purely combinational; depends on rv32e_pkg.
module rv32e_exec import rv32e_pkg::*; #(
  parameter int unsigned NumRegs = NumRegsDefault
) (
  input  in_word_t    word_i,
  input  logic [31:0] pc_i,
  input  logic        running_i,
  input  logic        awaiting_i,
  input  logic [8:0]  pending_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output out_word_t   res_o,
  output logic        running_o,
  output logic        awaiting_o,
  output logic [8:0]  pending_o,
  output logic        trap_o
);
  logic [31:0] w, immi, imms, immb, immu, immj, alu_b, alu_r, ld;
  logic [6:0]  op, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3, pf3;
  logic        bad_rd, bad_rs1, bad_rs2, ok, alt, taken;
  out_word_t   r;

  function automatic logic [31:0] alu(input logic [2:0] f, input logic [31:0] x,
                                      input logic [31:0] y, input logic s);
    logic [31:0] o;
    case (f)
      3'd0: o = s ? x - y : x + y;
      3'd1: o = x << y[4:0];
      3'd2: o = {31'd0, $signed(x) < $signed(y)};
      3'd3: o = {31'd0, x < y};
      3'd4: o = x ^ y;
      3'd5: o = s ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
      3'd6: o = x | y;
      default: o = x & y;
    endcase
    return o;
  endfunction

  always_comb begin
    w    = word_i.instruction;
    op   = w[6:0];
    rd   = w[11:7];
    f3   = w[14:12];
    rs1  = w[19:15];
    rs2  = w[24:20];
    f7   = w[31:25];
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immu = {w[31:12], 12'd0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    bad_rd  = {1'b0, rd}  >= 6'(NumRegs);
    bad_rs1 = {1'b0, rs1} >= 6'(NumRegs);
    bad_rs2 = {1'b0, rs2} >= 6'(NumRegs);
    alt   = 1'b0;
    alu_b = b_i;
    alu_r = '0;
    taken = 1'b0;
    ok    = 1'b1;
    pf3   = pending_i[7:5];
    ld    = word_i.load_data;

    r = '0;
    r.next_pc  = pc_i;
    running_o  = running_i;
    awaiting_o = awaiting_i;
    pending_o  = pending_i;
    trap_o     = 1'b0;

    if (running_i && !word_i.kind && !awaiting_i) begin
      if (word_i.mem_fault) begin
        ok = 1'b0;
        r.event_res = EvFault;
      end else begin
        unique case (op)
          OpLui: begin
            ok = !bad_rd;
            r.writeback_reg = rd; r.writeback_value = immu;
            r.next_pc = pc_i + 32'd4;
          end
          OpAuipc: begin
            ok = !bad_rd;
            r.writeback_reg = rd; r.writeback_value = pc_i + immu;
            r.next_pc = pc_i + 32'd4;
          end
          OpJal: begin
            ok = !bad_rd;
            r.writeback_reg = rd; r.writeback_value = pc_i + 32'd4;
            r.next_pc = pc_i + immj;
          end
          OpJalr: begin
            ok = f3 == 3'd0 && !bad_rd && !bad_rs1;
            r.writeback_reg = rd; r.writeback_value = pc_i + 32'd4;
            r.next_pc = (a_i + immi) & ~32'd1;
          end
          OpBranch: begin
            ok = !bad_rs1 && !bad_rs2;
            case (f3)
              3'd0: taken = a_i == b_i;
              3'd1: taken = a_i != b_i;
              3'd4: taken = $signed(a_i) < $signed(b_i);
              3'd5: taken = !($signed(a_i) < $signed(b_i));
              3'd6: taken = a_i < b_i;
              3'd7: taken = a_i >= b_i;
              default: ok = 1'b0;
            endcase
            r.next_pc = taken ? pc_i + immb : pc_i + 32'd4;
          end
          OpLoad: begin
            ok = !(f3 == 3'd3 || f3 >= 3'd6) && !bad_rd && !bad_rs1;
            r.mem_request = 1'b1; r.mem_size = f3[1:0];
            r.mem_address = a_i + immi;
            awaiting_o = 1'b1; pending_o = {1'b0, f3, rd};
          end
          OpStore: begin
            ok = f3 <= 3'd2 && !bad_rs1 && !bad_rs2;
            r.mem_request = 1'b1; r.mem_is_write = 1'b1; r.mem_size = f3[1:0];
            r.mem_address = a_i + imms; r.store_value = b_i;
            awaiting_o = 1'b1; pending_o = {1'b1, f3, 5'd0};
          end
          OpImm: begin
            ok = !bad_rd && !bad_rs1;
            alu_b = immi;
            if (f3 == 3'd1) begin
              ok = ok && f7 == 7'd0; alu_b = {27'd0, rs2};
            end else if (f3 == 3'd5) begin
              ok = ok && (f7 == 7'd0 || f7 == Funct7Alt);
              alt = f7 == Funct7Alt; alu_b = {27'd0, rs2};
            end
            alu_r = alu(f3, a_i, alu_b, alt);
            r.writeback_reg = rd; r.writeback_value = alu_r;
            r.next_pc = pc_i + 32'd4;
          end
          OpReg: begin
            ok = !bad_rd && !bad_rs1 && !bad_rs2 &&
                 (f7 == 7'd0 || (f7 == Funct7Alt && (f3 == 3'd0 || f3 == 3'd5)));
            r.writeback_reg = rd;
            r.writeback_value = alu(f3, a_i, b_i, f7 == Funct7Alt);
            r.next_pc = pc_i + 32'd4;
          end
          OpSystem: begin
            ok = f3 == 3'd0 && rd == 5'd0 && rs1 == 5'd0 &&
                 (w[31:20] == 12'd0 || w[31:20] == 12'd1);
            r.next_pc = pc_i + 32'd4;
            trap_o = 1'b1;
            if (w[31:20] == 12'd1) begin
              r.event_res = EvEbreak; running_o = 1'b0;
            end else begin
              r.event_res = EvEcall;
            end
          end
          OpFence: r.next_pc = pc_i + 32'd4;
          default: ok = 1'b0;
        endcase
        if (!ok) begin
          r = '0;
          r.next_pc = pc_i;
          r.event_res = EvIllegal;
          r.trap_value = w;
          awaiting_o = awaiting_i;
          pending_o = pending_i;
        end
      end
      if (!ok) begin
        running_o = 1'b0;
        trap_o = 1'b1;
      end
      r.writeback_valid = ok && r.writeback_reg != 5'd0 &&
                          (op == OpLui || op == OpAuipc || op == OpJal ||
                           op == OpJalr || op == OpImm || op == OpReg);
      if (!r.writeback_valid) begin
        r.writeback_reg = '0; r.writeback_value = '0;
      end
    end else if (running_i && word_i.kind && awaiting_i) begin
      awaiting_o = 1'b0;
      pending_o  = '0;
      if (word_i.mem_fault) begin
        r.event_res = EvFault; running_o = 1'b0; trap_o = 1'b1;
      end else begin
        r.next_pc = pc_i + 32'd4;
        if (!pending_i[8] && pending_i[4:0] != 5'd0) begin
          r.writeback_valid = 1'b1;
          r.writeback_reg = pending_i[4:0];
          case (pf3)
            3'd0: r.writeback_value = {{24{ld[7]}}, ld[7:0]};
            3'd1: r.writeback_value = {{16{ld[15]}}, ld[15:0]};
            3'd4: r.writeback_value = {24'd0, ld[7:0]};
            3'd5: r.writeback_value = {16'd0, ld[15:0]};
            default: r.writeback_value = ld;
          endcase
        end
      end
    end
    r.halted = !running_o;
    res_o = r;
  end
endmodule

[rtl/rv32i_execute_core.sv]
// Top level of the RV32I execute core: input stage, register file RAM,
// execute logic, output skid. Depends on rv32e_pkg, rv32e_stream_if, submodules.
//
//  channel   dir  word        notes
//  in_if     in   in_word_t   instruction or memory response
//  out_if    out  out_word_t  one result word per input word
//  cfg       in   index/data  0 start address, 1 initial sp
//
// One word per cycle while the buffer has room: an accepted word reads rs1/rs2
// from the RAM in the cycle it is taken, executes the next cycle from the
// registered read data. Back-to-back writes to a source register are forwarded
// around the RAM. A two-entry output buffer holds results while out_if stalls;
// input is taken while a slot is free. No clearing pass after reset.
module rv32i_execute_core import rv32e_pkg::*; #(
  parameter int unsigned NumRegs = NumRegsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  rv32e_stream_if.sink   in_if,
  rv32e_stream_if.source out_if
);
  logic [31:0] pc_q, sp_q;
  logic        running_q, awaiting_q;
  logic [8:0]  pending_q;
  logic [31:0] trap_pc_q, trap_info_q;
  logic [2:0]  trap_cause_q;

  logic        ex_valid_q;
  in_word_t    ex_word_q;
  logic [31:0] rs_a, rs_b;

  out_word_t   res;
  logic [31:0] pc_d;
  logic        running_d, awaiting_d, trap;
  logic [8:0]  pending_d;

  out_word_t   buf_q [2];
  logic        rd_ptr_q, wr_ptr_q;
  logic [1:0]  cnt_q;
  logic        in_fire, out_fire;
  logic        sp_wr;

  // at most one word in flight plus the buffer: keep room for it
  assign in_if.ready = (cnt_q + {1'b0, ex_valid_q}) < 2'd2 || out_fire;
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_if.valid = cnt_q != 2'd0;
  assign out_if.data  = buf_q[rd_ptr_q];
  assign out_fire     = out_if.valid && out_if.ready;
  assign sp_wr        = cfg_we_i && cfg_index_i == CfgStackPtr;

  rv32e_regfile #(.NumRegs(NumRegs)) u_rf (
    .clk_i,
    .rst_ni,
    .we_i      ((ex_valid_q && res.writeback_valid) || sp_wr),
    .waddr_i   (sp_wr ? RegSp : res.writeback_reg),
    .wdata_i   (sp_wr ? cfg_data_i : res.writeback_value),
    .raddr_a_i (in_if.data.instruction[19:15]),
    .raddr_b_i (in_if.data.instruction[24:20]),
    .sp_i      (sp_q),
    .rdata_a_o (rs_a),
    .rdata_b_o (rs_b)
  );

  rv32e_exec #(.NumRegs(NumRegs)) u_exec (
    .word_i     (ex_word_q),
    .pc_i       (pc_q),
    .running_i  (running_q),
    .awaiting_i (awaiting_q),
    .pending_i  (pending_q),
    .a_i        (rs_a),
    .b_i        (rs_b),
    .res_o      (res),
    .running_o  (running_d),
    .awaiting_o (awaiting_d),
    .pending_o  (pending_d),
    .trap_o     (trap)
  );

  assign pc_d = res.next_pc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= '0;
      sp_q         <= StackResetValue;
      running_q    <= 1'b1;
      awaiting_q   <= 1'b0;
      pending_q    <= '0;
      trap_pc_q    <= '0;
      trap_cause_q <= EvNone;
      trap_info_q  <= '0;
      ex_valid_q   <= 1'b0;
      rd_ptr_q     <= 1'b0;
      wr_ptr_q     <= 1'b0;
      cnt_q        <= '0;
    end else begin
      ex_valid_q <= in_fire;
      if (cfg_we_i && cfg_index_i == CfgStartAddr) begin
        pc_q <= cfg_data_i;
      end
      if (sp_wr) begin
        sp_q <= cfg_data_i;
      end
      if (ex_valid_q) begin
        pc_q       <= pc_d;
        running_q  <= running_d;
        awaiting_q <= awaiting_d;
        pending_q  <= pending_d;
        if (trap) begin
          trap_pc_q    <= pc_q;
          trap_cause_q <= res.event_res;
          trap_info_q  <= res.trap_value;
        end
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_fire) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, ex_valid_q} - {1'b0, out_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_word_q <= in_if.data;
    end
    if (ex_valid_q) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  // trap records are kept internally; no port or buffer slot reads them
  logic unused_trap;
  assign unused_trap = ^{trap_pc_q, trap_cause_q, trap_info_q};
endmodule

[tb/rv32i_execute_core_test.sv]
// Self-checking testbench for rv32i_execute_core: random RV32I programs with
// memory responses, checked against an in-bench instruction-level predictor.
// Depends on rv32e_pkg, rv32e_stream_if and the core RTL.
`timescale 1ns / 1ps

module rv32i_execute_core_test;
  import rv32e_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 8;

  localparam logic [2:0] F3AddSub = 3'd0, F3Sll = 3'd1, F3Slt = 3'd2, F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor = 3'd4, F3Srl = 3'd5, F3Or = 3'd6, F3And = 3'd7;
  localparam logic [2:0] F3Beq = 3'd0, F3Bne = 3'd1, F3Blt = 3'd4, F3Bge = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6, F3Bgeu = 3'd7;
  localparam logic [2:0] F3Byte = 3'd0, F3Half = 3'd1, F3Word = 3'd2;
  localparam logic [2:0] F3ByteU = 3'd4, F3HalfU = 3'd5;
  localparam logic [11:0] SysEcall = 12'd0, SysEbreak = 12'd1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  rv32e_stream_if #(.word_t(in_word_t))  in_ch ();
  rv32e_stream_if #(.word_t(out_word_t)) out_ch ();

  rv32i_execute_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // architectural state of the predicted hart
  logic [31:0] gpr_q [32];
  logic [31:0] pc_q;
  logic        run_q;
  logic        await_q;
  logic [4:0]  pend_rd;
  logic [2:0]  pend_f3;
  logic        pend_st;

  in_word_t    word_feed_q [$];
  out_word_t   result_exp_q [$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned err_cnt, cycle_cnt, hold_cnt;
  logic        hold_req;

  function automatic logic [31:0] alu(logic [2:0] f3, logic [31:0] a, logic [31:0] b,
                                      logic alt);
    case (f3)
      F3AddSub: return alt ? a - b : a + b;
      F3Sll:    return a << b[4:0];
      F3Slt:    return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3Sltu:   return (a < b) ? 32'd1 : 32'd0;
      F3Xor:    return a ^ b;
      F3Srl:    return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3Or:     return a | b;
      default:  return a & b;
    endcase
  endfunction

  // executes one word against the predicted state, returns the expected result
  function automatic out_word_t exec_word(in_word_t w);
    out_word_t   r;
    logic [31:0] ins, a, b, immi, imms, immb, immj, wv;
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic        ok, we, tk;
    r = '0;
    ins = w.instruction;
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
    rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
    a = gpr_q[rs1]; b = gpr_q[rs2];
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    ok = 1'b1; we = 1'b0; wv = '0;
    if (run_q && !w.kind && !await_q) begin
      if (w.mem_fault) begin
        r.event_res = EvFault; run_q = 1'b0;
      end else begin
        case (op)
          OpLui: begin
            we = 1'b1; wv = {ins[31:12], 12'd0}; pc_q += 4;
          end
          OpAuipc: begin
            we = 1'b1; wv = pc_q + {ins[31:12], 12'd0}; pc_q += 4;
          end
          OpJal: begin
            we = 1'b1; wv = pc_q + 4; pc_q += immj;
          end
          OpJalr: begin
            if (f3 != 3'd0) ok = 1'b0;
            else begin
              we = 1'b1; wv = pc_q + 4; pc_q = (a + immi) & ~32'd1;
            end
          end
          OpBranch: begin
            tk = 1'b0;
            case (f3)
              F3Beq:  tk = a == b;
              F3Bne:  tk = a != b;
              F3Blt:  tk = $signed(a) < $signed(b);
              F3Bge:  tk = $signed(a) >= $signed(b);
              F3Bltu: tk = a < b;
              F3Bgeu: tk = a >= b;
              default: ok = 1'b0;
            endcase
            if (ok) pc_q = tk ? pc_q + immb : pc_q + 4;
          end
          OpLoad: begin
            if (f3 == 3'd3 || f3 >= 3'd6) ok = 1'b0;
            else begin
              r.mem_request = 1'b1; r.mem_size = f3[1:0]; r.mem_address = a + immi;
              await_q = 1'b1; pend_rd = rd; pend_f3 = f3; pend_st = 1'b0;
            end
          end
          OpStore: begin
            if (f3 > F3Word) ok = 1'b0;
            else begin
              r.mem_request = 1'b1; r.mem_is_write = 1'b1; r.mem_size = f3[1:0];
              r.mem_address = a + imms; r.store_value = b;
              await_q = 1'b1; pend_rd = '0; pend_f3 = f3; pend_st = 1'b1;
            end
          end
          OpImm: begin
            if (f3 == F3Sll && f7 != 7'd0) ok = 1'b0;
            else if (f3 == F3Srl && f7 != 7'd0 && f7 != Funct7Alt) ok = 1'b0;
            else begin
              we = 1'b1; pc_q += 4;
              wv = alu(f3, a, (f3 == F3Sll || f3 == F3Srl) ? 32'(rs2) : immi,
                       f3 == F3Srl && f7 == Funct7Alt);
            end
          end
          OpReg: begin
            if (f7 != 7'd0 && !(f7 == Funct7Alt && (f3 == F3AddSub || f3 == F3Srl)))
              ok = 1'b0;
            else begin
              we = 1'b1; wv = alu(f3, a, b, f7 == Funct7Alt); pc_q += 4;
            end
          end
          OpSystem: begin
            if (f3 != 3'd0 || rd != 5'd0 || rs1 != 5'd0) ok = 1'b0;
            else if (ins[31:20] == SysEcall) begin
              r.event_res = EvEcall; pc_q += 4;
            end else if (ins[31:20] == SysEbreak) begin
              r.event_res = EvEbreak; run_q = 1'b0; pc_q += 4;
            end else ok = 1'b0;
          end
          OpFence: pc_q += 4;
          default: ok = 1'b0;
        endcase
        if (!ok) begin
          r.event_res = EvIllegal; r.trap_value = ins; run_q = 1'b0;
        end
      end
    end else if (run_q && w.kind && await_q) begin
      await_q = 1'b0;
      if (w.mem_fault) begin
        r.event_res = EvFault; run_q = 1'b0;
      end else begin
        if (!pend_st) begin
          rd = pend_rd; we = 1'b1;
          case (pend_f3)
            F3Byte:  wv = {{24{w.load_data[7]}}, w.load_data[7:0]};
            F3Half:  wv = {{16{w.load_data[15]}}, w.load_data[15:0]};
            F3ByteU: wv = {24'd0, w.load_data[7:0]};
            F3HalfU: wv = {16'd0, w.load_data[15:0]};
            default: wv = w.load_data;
          endcase
        end
        pc_q += 4;
      end
    end
    if (we && rd != 5'd0) begin
      gpr_q[rd] = wv;
      r.writeback_valid = 1'b1; r.writeback_reg = rd; r.writeback_value = wv;
    end
    r.next_pc = pc_q;
    r.halted = !run_q;
    return r;
  endfunction

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction
  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpStore};
  endfunction
  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpBranch};
  endfunction
  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OpJal};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  // instruction word; load_data random since it is unused
  task automatic put_ins(logic [31:0] ins, logic flt = 1'b0);
    in_word_t w;
    w.kind = 1'b0; w.instruction = ins; w.load_data = $urandom; w.mem_fault = flt;
    word_feed_q.push_back(w);
  endtask

  task automatic put_rsp(logic [31:0] data, logic flt = 1'b0);
    in_word_t w;
    w.kind = 1'b1; w.instruction = $urandom; w.load_data = data; w.mem_fault = flt;
    word_feed_q.push_back(w);
  endtask

  // memory access, sometimes with a stray fetch while the response is due
  task automatic put_access(logic [31:0] ins, logic [31:0] data);
    put_ins(ins);
    if ($urandom_range(0, 7) == 0) put_ins($urandom, 1'($urandom));
    put_rsp(data);
  endtask

  task automatic put_random_op();
    logic [2:0] f3;
    logic [4:0] rd, rs1, rs2;
    rd = pick_reg(); rs1 = pick_reg(); rs2 = pick_reg();
    f3 = 3'($urandom);
    case ($urandom_range(0, 13))
      0:  put_ins({20'($urandom), rd, OpLui});
      1:  put_ins({20'($urandom), rd, OpAuipc});
      2:  put_ins(enc_j(21'($urandom), rd));
      3:  put_ins(enc_i(12'($urandom), rs1, 3'd0, rd, OpJalr));
      4:  put_ins(enc_b(13'($urandom), rs2, rs1,
                        (f3 == 3'd2 || f3 == 3'd3) ? F3Beq : f3));
      5, 6: begin
        if (f3 == F3Sll)
          put_ins(enc_r(7'd0, rs2, rs1, f3, rd, OpImm));
        else if (f3 == F3Srl)
          put_ins(enc_r($urandom_range(0, 1) ? Funct7Alt : 7'd0, rs2, rs1, f3, rd, OpImm));
        else
          put_ins(enc_i(12'($urandom), rs1, f3, rd, OpImm));
      end
      7, 8: put_ins(enc_r((f3 == F3AddSub || f3 == F3Srl) && $urandom_range(0, 1) ?
                          Funct7Alt : 7'd0, rs2, rs1, f3, rd, OpReg));
      9, 10: begin
        case ($urandom_range(0, 4))
          0: f3 = F3Byte; 1: f3 = F3Half; 2: f3 = F3Word; 3: f3 = F3ByteU;
          default: f3 = F3HalfU;
        endcase
        put_access(enc_i(12'($urandom), rs1, f3, rd, OpLoad), $urandom);
      end
      11: put_access(enc_s(12'($urandom), rs2, rs1, 3'($urandom_range(0, 2))), $urandom);
      12: put_ins($urandom_range(0, 1) ? {25'($urandom), OpFence}
                                       : enc_i(SysEcall, 5'd0, 3'd0, 5'd0, OpSystem));
      default: put_rsp($urandom, 1'($urandom));  // nothing pending: ignored
    endcase
  endtask

  // halting happens once per run, so it closes the stimulus
  task automatic put_halt();
    logic [31:0] ins;
    case ($urandom_range(0, 10))
      0: put_ins($urandom, 1'b1);
      1: begin
        put_ins(enc_i(12'($urandom), pick_reg(), F3Word, pick_reg(), OpLoad));
        put_rsp($urandom, 1'b1);
      end
      2: begin
        put_ins(enc_s(12'($urandom), pick_reg(), pick_reg(), F3Byte));
        put_rsp($urandom, 1'b1);
      end
      3: put_ins(enc_i(SysEbreak, 5'd0, 3'd0, 5'd0, OpSystem));
      4: put_ins(enc_i(12'($urandom_range(2, 4095)), 5'($urandom), 3'($urandom),
                       5'($urandom), OpSystem));
      5: put_ins(enc_i(12'($urandom), pick_reg(), 3'($urandom_range(1, 7)), pick_reg(),
                       OpJalr));
      6: put_ins(enc_b(13'($urandom), pick_reg(), pick_reg(), 3'($urandom_range(2, 3))));
      7: put_ins(enc_i(12'($urandom), pick_reg(), $urandom_range(0, 1) ? 3'd3 : 3'd7,
                       pick_reg(), OpLoad));
      8: put_ins(enc_s(12'($urandom), pick_reg(), pick_reg(), 3'($urandom_range(3, 7))));
      9: put_ins(enc_r(7'($urandom_range(1, 127)), 5'($urandom), pick_reg(), F3Sll,
                       pick_reg(), OpImm));
      default: begin
        do begin
          ins = $urandom;
        end while (ins[6:0] inside {OpLui, OpAuipc, OpJal, OpJalr, OpBranch, OpLoad,
                                    OpStore, OpImm, OpReg, OpSystem, OpFence});
        put_ins(ins);
      end
    endcase
    repeat (4) begin
      if ($urandom_range(0, 1)) put_ins($urandom, 1'($urandom));
      else put_rsp($urandom, 1'($urandom));
    end
  endtask

  task automatic put_directed();
    put_ins({20'hFFFFF, 5'd31, OpLui});
    put_ins(enc_i(12'h800, 5'd0, F3AddSub, 5'd3, OpImm));
    put_ins(enc_i(12'h7FF, 5'd0, F3AddSub, 5'd4, OpImm));
    put_ins(enc_r(7'd0, 5'd4, 5'd3, F3AddSub, 5'd0, OpReg));
    put_ins(enc_r(Funct7Alt, 5'd4, 5'd3, F3AddSub, 5'd5, OpReg));
    put_ins(enc_r(Funct7Alt, 5'd4, 5'd3, F3Srl, 5'd6, OpReg));
    put_ins(enc_r(Funct7Alt, 5'd31, 5'd31, F3Srl, 5'd7, OpImm));
    put_ins(enc_r(7'd0, 5'd31, 5'd31, F3Srl, 5'd8, OpImm));
    put_ins(enc_r(7'd0, 5'd31, 5'd4, F3Sll, 5'd9, OpImm));
    put_ins(enc_r(7'd0, 5'd4, 5'd3, F3Slt, 5'd10, OpReg));
    put_ins(enc_r(7'd0, 5'd4, 5'd3, F3Sltu, 5'd11, OpReg));
    put_ins({20'h80000, 5'd12, OpAuipc});
    put_ins(enc_j(21'h1FFFFC, 5'd1));
    put_ins(enc_i(12'h7FF, 5'd3, 3'd0, 5'd13, OpJalr));
    put_ins(enc_b(13'h1000, 5'd0, 5'd0, F3Beq));
    put_ins(enc_b(13'h0FFE, 5'd0, 5'd0, F3Bne));
    put_ins(enc_b(13'h0008, 5'd4, 5'd3, F3Blt));
    put_ins(enc_b(13'h0008, 5'd4, 5'd3, F3Bge));
    put_ins(enc_b(13'h0008, 5'd4, 5'd3, F3Bltu));
    put_ins(enc_b(13'h0008, 5'd4, 5'd3, F3Bgeu));
    put_ins({25'($urandom), OpFence});
    put_ins(enc_i(SysEcall, 5'd0, 3'd0, 5'd0, OpSystem));
    put_access(enc_i(12'hFFF, 5'd2, F3Byte, 5'd14, OpLoad), 32'h0000_0080);
    put_access(enc_i(12'h000, 5'd31, F3HalfU, 5'd15, OpLoad), 32'hFFFF_8000);
    put_access(enc_i(12'h7FF, 5'd2, F3Half, 5'd16, OpLoad), 32'h0000_8001);
    put_access(enc_i(12'h800, 5'd2, F3ByteU, 5'd17, OpLoad), 32'hFFFF_FFFF);
    put_access(enc_i(12'h004, 5'd0, F3Word, 5'd0, OpLoad), 32'hDEAD_BEEF);
    put_access(enc_s(12'h800, 5'd31, 5'd2, F3Byte), $urandom);
    put_access(enc_s(12'h7FF, 5'd5, 5'd3, F3Half), $urandom);
    put_ins(enc_s(12'h000, 5'd0, 5'd0, F3Word));
    put_ins($urandom, 1'b1);  // fetch while awaiting: ignored
    put_rsp($urandom);
    put_rsp($urandom, 1'b1);  // nothing pending: ignored
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgStartAddr) pc_q = val;
    else gpr_q[RegSp] = val;
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n_ops);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (n_ops) put_random_op();
    while (word_feed_q.size() != 0 || result_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_exp_q.push_back(exec_word(in_ch.data));
        void'(word_feed_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // word stays on the channel
      end else if (word_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= word_feed_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_req) hold_cnt <= 400;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= hold_cnt == 0 && $urandom_range(0, 99) >= recv_stall_pct;
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t: %s expected %h got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (result_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: result word with none expected", $realtime);
      end else begin
        out_word_t e;
        e = result_exp_q.pop_front();
        check_field("next_pc", e.next_pc, out_ch.data.next_pc);
        check_field("event_res", 32'(e.event_res), 32'(out_ch.data.event_res));
        check_field("halted", 32'(e.halted), 32'(out_ch.data.halted));
        check_field("trap_value", e.trap_value, out_ch.data.trap_value);
        check_field("mem_request", 32'(e.mem_request), 32'(out_ch.data.mem_request));
        check_field("mem_is_write", 32'(e.mem_is_write), 32'(out_ch.data.mem_is_write));
        check_field("mem_size", 32'(e.mem_size), 32'(out_ch.data.mem_size));
        check_field("mem_address", e.mem_address, out_ch.data.mem_address);
        check_field("store_value", e.store_value, out_ch.data.store_value);
        check_field("writeback_valid", 32'(e.writeback_valid),
                    32'(out_ch.data.writeback_valid));
        check_field("writeback_reg", 32'(e.writeback_reg), 32'(out_ch.data.writeback_reg));
        check_field("writeback_value", e.writeback_value, out_ch.data.writeback_value);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("rv32i_execute_core: mismatch");
      $finish;
    end
  end

  initial begin
    cfg_we_i = 1'b0; cfg_index_i = CfgStartAddr; cfg_data_i = '0;
    hold_req = 1'b0; err_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    foreach (gpr_q[i]) gpr_q[i] = '0;
    gpr_q[RegSp] = StackResetValue;
    pc_q = '0; run_q = 1'b1; await_q = 1'b0;
    pend_rd = '0; pend_f3 = '0; pend_st = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    put_directed();
    run_phase(0, 0, 300);

    write_cfg(CfgStartAddr, 32'hFFFF_FFFF);
    write_cfg(CfgStackPtr, 32'h0000_0000);
    run_phase(48, 0, 320);

    write_cfg(CfgStartAddr, 32'h0000_0000);
    write_cfg(CfgStackPtr, 32'hFFFF_FFFF);
    @(posedge clk_i);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    run_phase(0, 48, 320);

    write_cfg(CfgStartAddr, $urandom);
    write_cfg(CfgStackPtr, StackResetValue);
    run_phase(37, 37, 320);

    put_halt();
    run_phase(0, 0, 0);

    if (result_exp_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("rv32i_execute_core: match");
    end else begin
      $display("rv32i_execute_core: mismatch");
    end
    $finish;
  end

endmodule
